/* hdl/weighted_visibility_group_average_macros.svh */
// assertion macros used by the checker file
`ifndef WEIGHTED_VISIBILITY_GROUP_AVERAGE_MACROS_SVH
`define WEIGHTED_VISIBILITY_GROUP_AVERAGE_MACROS_SVH

// same-cycle implication, quiet while in reset
`define WVGA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet while in reset
`define WVGA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked through reset as well
`define WVGA_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/wvga_pkg.sv */
// shared types and constants of the visibility group averager
package wvga_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int MAX_POL      = 4;
  localparam int ELEM_W       = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = ELEM_W + 1;
  localparam int POL_W        = $clog2(MAX_POL);

  typedef logic [1:0] div_sel_t;
  localparam div_sel_t SEL_TIME = 2'd0;
  localparam div_sel_t SEL_INTV = 2'd1;
  localparam div_sel_t SEL_REAL = 2'd2;
  localparam div_sel_t SEL_IMAG = 2'd3;

  localparam logic CFG_NUM_POL    = 1'b0;
  localparam logic CFG_CHAN_COUNT = 1'b1;

  typedef struct packed {
    logic     cap;
    logic     mul;
    logic     prod;
    logic     wr;
    logic     emit_init;
    logic     rd;
    logic     div_go;
    div_sel_t div_sel;
    logic     emit_next;
    logic     clr;
    logic     close;
  } wvga_cmd_t;

  typedef struct packed {
    logic func;
    logic open;
    logic key_match;
    logic div_done;
    logic last_elem;
  } wvga_sts_t;

endpackage

/* hdl/wvga_div.sv */
// restoring divider, one quotient bit per cycle
module wvga_div import wvga_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dvd,
  input  logic [47:0] dvs,
  output logic        done,
  output logic [63:0] quot
);

  logic [63:0] q_r;
  logic [47:0] rem_r, dvs_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [48:0] rem_sh, rem_sub;
  logic        ge;

  assign rem_sh  = {rem_r, q_r[63]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (&cnt_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dvd;
      rem_r <= '0;
      dvs_r <= dvs;
    end else if (busy_r) begin
      q_r   <= {q_r[62:0], ge};
      rem_r <= ge ? rem_sub[47:0] : rem_sh[47:0];
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* hdl/wvga_ctrl.sv */
// sequencer for accumulation and group emission
module wvga_ctrl import wvga_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  wvga_sts_t sts,
  output wvga_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_T_GO = 4'd2;
  localparam logic [3:0] S_T_WT = 4'd3;
  localparam logic [3:0] S_I_GO = 4'd4;
  localparam logic [3:0] S_I_WT = 4'd5;
  localparam logic [3:0] S_RD   = 4'd6;
  localparam logic [3:0] S_R_GO = 4'd7;
  localparam logic [3:0] S_R_WT = 4'd8;
  localparam logic [3:0] S_M_GO = 4'd9;
  localparam logic [3:0] S_M_WT = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;
  localparam logic [3:0] S_CLR  = 4'd12;
  localparam logic [3:0] S_MUL  = 4'd13;
  localparam logic [3:0] S_PROD = 4'd14;
  localparam logic [3:0] S_WR   = 4'd15;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.func) begin
          state_nxt = sts.open ? S_T_GO : S_IDLE;
        end else begin
          state_nxt = (sts.open && !sts.key_match) ? S_T_GO : S_MUL;
        end
      end
      S_T_GO: begin
        cmd.div_go    = 1'b1;
        cmd.div_sel   = SEL_TIME;
        cmd.emit_init = 1'b1;
        state_nxt     = S_T_WT;
      end
      S_T_WT: if (sts.div_done) state_nxt = S_I_GO;
      S_I_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = SEL_INTV;
        state_nxt   = S_I_WT;
      end
      S_I_WT: if (sts.div_done) state_nxt = S_RD;
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_R_GO;
      end
      S_R_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = SEL_REAL;
        state_nxt   = S_R_WT;
      end
      S_R_WT: if (sts.div_done) state_nxt = S_M_GO;
      S_M_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = SEL_IMAG;
        state_nxt   = S_M_WT;
      end
      S_M_WT: if (sts.div_done) state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          if (sts.last_elem) begin
            state_nxt = S_CLR;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = S_RD;
          end
        end
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.func) begin
          cmd.close = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* hdl/wvga_dp.sv */
// sums, element memories, divider and result registers
module wvga_dp import wvga_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  wvga_cmd_t           cmd,
  output wvga_sts_t           sts,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_wdata,
  input  logic                in_func,
  input  logic [47:0]         in_group_key,
  input  logic signed [31:0]  in_sample_real,
  input  logic signed [31:0]  in_sample_imag,
  input  logic                in_flagged,
  input  logic [15:0]         in_pol_weight,
  input  logic [15:0]         in_row_interval,
  input  logic [39:0]         in_row_time,
  output logic [47:0]         out_key,
  output logic [ELEM_W-1:0]   out_elem_index,
  output logic signed [31:0]  out_avg_real,
  output logic signed [31:0]  out_avg_imag,
  output logic [39:0]         out_avg_time,
  output logic [15:0]         out_avg_interval,
  output logic [15:0]         out_rows_in_group,
  output logic                out_last
);

  function automatic logic signed [63:0] sadd64(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic [31:0] sat32(logic signed [63:0] v);
    if (!v[63] && (|v[62:31])) return 32'h7FFF_FFFF;
    if (v[63] && !(&v[62:31])) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] fin32(logic signed [63:0] num, logic [47:0] den,
                                        logic [63:0] q);
    if (den == '0) return sat32(num);
    if (num[63]) begin
      if (|q[63:31]) return 32'h8000_0000;
      return ~q[31:0] + 32'd1;
    end
    if (|q[63:31]) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // configuration
  logic [2:0] num_pol_r;
  logic [6:0] chan_cnt_r;
  logic [2:0] np;
  logic [6:0] nc;
  logic [9:0] nprod;
  logic [CNT_W-1:0] n_elem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_pol_r  <= 3'd4;
      chan_cnt_r <= 7'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_POL:    num_pol_r  <= cfg_wdata[2:0];
        CFG_CHAN_COUNT: chan_cnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_pol_r == 3'd0) np = 3'd1;
    else if (num_pol_r > 3'(MAX_POL)) np = 3'(MAX_POL);
    else np = num_pol_r;
    nc    = (chan_cnt_r == 7'd0) ? 7'd1 : chan_cnt_r;
    nprod = 10'(nc) * 10'(np);
    n_elem = (nprod > 10'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : nprod[CNT_W-1:0];
  end

  // latched input transaction
  logic               func_r, flag_r;
  logic [47:0]        key_r;
  logic signed [31:0] sre_r, sim_r;
  logic [15:0]        w_r, tint_r;
  logic [39:0]        time_r;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_r <= in_func;
      key_r  <= in_group_key;
      sre_r  <= in_sample_real;
      sim_r  <= in_sample_imag;
      flag_r <= in_flagged;
      w_r    <= in_pol_weight;
      tint_r <= in_row_interval;
      time_r <= in_row_time;
    end
  end

  // group state
  logic                group_open_r;
  logic [47:0]         open_key_r;
  logic [47:0]         wsum_r [MAX_POL];
  logic [55:0]         tsum_r;
  logic [31:0]         isum_r;
  logic [15:0]         rcnt_r;
  logic [ELEM_W-1:0]   epos_r;

  // accumulation pipeline
  logic [31:0]         wi_r;
  logic [ELEM_W-1:0]   pos_r;
  logic signed [63:0]  pre_r, pim_r;
  logic [ELEM_W-1:0]   pos_nxt;
  logic [CNT_W-1:0]    pos_inc;

  assign pos_nxt = ({1'b0, epos_r} >= n_elem) ? '0 : epos_r;
  assign pos_inc = {1'b0, pos_r} + CNT_W'(1);

  // element memories with per-entry valid bits
  logic signed [63:0]  mem_re [MAX_ELEMENTS];
  logic signed [63:0]  mem_im [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] vld_r;
  logic signed [63:0]  rd_re_r, rd_im_r;
  logic                rd_v_r;
  logic [ELEM_W-1:0]   rd_addr;
  logic [ELEM_W-1:0]   e_r;
  logic [POL_W-1:0]    p_r;
  logic signed [63:0]  cur_re, cur_im;

  assign rd_addr = cmd.prod ? pos_r : e_r;
  assign cur_re  = rd_v_r ? rd_re_r : 64'sd0;
  assign cur_im  = rd_v_r ? rd_im_r : 64'sd0;

  always_ff @(posedge clk) begin
    if (cmd.wr && !flag_r) begin
      mem_re[pos_r] <= sadd64(cur_re, pre_r);
      mem_im[pos_r] <= sadd64(cur_im, pim_r);
    end
    if (cmd.rd || cmd.prod) begin
      rd_re_r <= mem_re[rd_addr];
      rd_im_r <= mem_im[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      vld_r <= '0;
    end else if (cmd.wr && !flag_r) begin
      vld_r[pos_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd || cmd.prod) rd_v_r <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      wi_r  <= 32'(w_r) * 32'(tint_r);
      pos_r <= pos_nxt;
    end
    if (cmd.prod) begin
      pre_r <= 64'(sre_r * $signed({1'b0, wi_r}));
      pim_r <= 64'(sim_r * $signed({1'b0, wi_r}));
    end
  end

  logic [48:0] wsum_add;
  logic [56:0] tsum_add;
  logic [32:0] isum_add;

  assign wsum_add = {1'b0, wsum_r[pos_r[POL_W-1:0]]} + 49'(wi_r);
  assign tsum_add = {1'b0, tsum_r} + 57'(time_r);
  assign isum_add = {1'b0, isum_r} + 33'(tint_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_open_r <= 1'b0;
      open_key_r   <= '0;
      tsum_r       <= '0;
      isum_r       <= '0;
      rcnt_r       <= '0;
      epos_r       <= '0;
      for (int i = 0; i < MAX_POL; i++) wsum_r[i] <= '0;
    end else if (cmd.clr) begin
      tsum_r <= '0;
      isum_r <= '0;
      rcnt_r <= '0;
      epos_r <= '0;
      for (int i = 0; i < MAX_POL; i++) wsum_r[i] <= '0;
      if (cmd.close) group_open_r <= 1'b0;
    end else if (cmd.mul) begin
      group_open_r <= 1'b1;
      open_key_r   <= key_r;
    end else if (cmd.wr) begin
      if (pos_r == '0) begin
        tsum_r <= tsum_add[56] ? {56{1'b1}} : tsum_add[55:0];
        isum_r <= isum_add[32] ? {32{1'b1}} : isum_add[31:0];
        if (rcnt_r != 16'hFFFF) rcnt_r <= rcnt_r + 16'd1;
      end
      if ({1'b0, pos_r} < CNT_W'(np)) begin
        wsum_r[pos_r[POL_W-1:0]] <= wsum_add[48] ? {48{1'b1}} : wsum_add[47:0];
      end
      epos_r <= (pos_inc >= n_elem) ? '0 : pos_inc[ELEM_W-1:0];
    end
  end

  // emission
  logic [2:0]         p_inc;
  logic [63:0]        dvd;
  logic [47:0]        dvs;
  logic               div_done;
  logic [63:0]        quot;
  div_sel_t           dsel_r;
  logic [39:0]        avg_t_r;
  logic [15:0]        avg_i_r;
  logic [31:0]        avg_re_r, avg_im_r;
  logic [47:0]        wcur;

  assign p_inc = 3'(p_r) + 3'd1;
  assign wcur  = wsum_r[p_r];

  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      e_r <= '0;
      p_r <= '0;
    end else if (cmd.emit_next) begin
      e_r <= e_r + ELEM_W'(1);
      p_r <= (p_inc >= np) ? '0 : p_inc[POL_W-1:0];
    end
  end

  always_comb begin
    case (cmd.div_sel)
      SEL_TIME: begin
        dvd = 64'(tsum_r);
        dvs = 48'(rcnt_r);
      end
      SEL_INTV: begin
        dvd = 64'(isum_r);
        dvs = 48'(rcnt_r);
      end
      SEL_REAL: begin
        dvd = cur_re[63] ? 64'(-cur_re) : 64'(cur_re);
        dvs = wcur;
      end
      default: begin
        dvd = cur_im[63] ? 64'(-cur_im) : 64'(cur_im);
        dvs = wcur;
      end
    endcase
  end

  wvga_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .dvd   (dvd),
    .dvs   (dvs),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_go) dsel_r <= cmd.div_sel;
    if (div_done) begin
      case (dsel_r)
        SEL_TIME: avg_t_r <= (rcnt_r == '0) ? '0 :
                             ((|quot[63:40]) ? {40{1'b1}} : quot[39:0]);
        SEL_INTV: avg_i_r <= (rcnt_r == '0) ? '0 :
                             ((|quot[63:16]) ? 16'hFFFF : quot[15:0]);
        SEL_REAL: avg_re_r <= fin32(cur_re, wcur, quot);
        default:  avg_im_r <= fin32(cur_im, wcur, quot);
      endcase
    end
  end

  assign sts.func      = func_r;
  assign sts.open      = group_open_r;
  assign sts.key_match = (key_r == open_key_r);
  assign sts.div_done  = div_done;
  assign sts.last_elem = ({1'b0, e_r} == n_elem - CNT_W'(1));

  assign out_key           = open_key_r;
  assign out_elem_index    = e_r;
  assign out_avg_real      = avg_re_r;
  assign out_avg_imag      = avg_im_r;
  assign out_avg_time      = avg_t_r;
  assign out_avg_interval  = avg_i_r;
  assign out_rows_in_group = rcnt_r;
  assign out_last          = sts.last_elem;

endmodule

/* hdl/weighted_visibility_group_average.sv */
// top level of the weighted visibility group averager
// Input channel (in_*): one visibility element or a flush per transaction,
// taken when in_valid is high and in_stall low. Result channel (out_*):
// one averaged element per transaction, taken when out_valid is high and
// out_stall low. cfg_we/cfg_index/cfg_wdata set the polarisation count (0)
// and the channel count (1). The user must write them only while the block
// is idle; the block itself does not enforce this. After acceptance an
// element passes a decode step, a weight multiply, the sample products,
// then a saturating read-modify-write of its sum entry in the element
// memory before the next element is taken. A key change or a flush emits
// the open group: the mean time and interval each take one 64-step pass of
// the shared bit-serial divider, then every element needs a memory read,
// two divider passes and its output handshake. Input is stalled throughout
// emission; a stalled result holds, and the sequencer waits on it. The
// element that caused a key change is summed afterwards.
// Synchronous reset clears all sums and valid bits at once, closes the
// group and restores 4 polarisations and 16 channels; no clearing pass.
module weighted_visibility_group_average import wvga_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  input  logic [47:0]         in_group_key,
  input  logic signed [31:0]  in_sample_real,
  input  logic signed [31:0]  in_sample_imag,
  input  logic                in_flagged,
  input  logic [15:0]         in_pol_weight,
  input  logic [15:0]         in_row_interval,
  input  logic [39:0]         in_row_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [47:0]         out_key,
  output logic [5:0]          out_elem_index,
  output logic signed [31:0]  out_avg_real,
  output logic signed [31:0]  out_avg_imag,
  output logic [39:0]         out_avg_time,
  output logic [15:0]         out_avg_interval,
  output logic [15:0]         out_rows_in_group,
  output logic                out_last
);

  wvga_cmd_t cmd;
  wvga_sts_t sts;

  wvga_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  wvga_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_func           (in_func),
    .in_group_key      (in_group_key),
    .in_sample_real    (in_sample_real),
    .in_sample_imag    (in_sample_imag),
    .in_flagged        (in_flagged),
    .in_pol_weight     (in_pol_weight),
    .in_row_interval   (in_row_interval),
    .in_row_time       (in_row_time),
    .out_key           (out_key),
    .out_elem_index    (out_elem_index),
    .out_avg_real      (out_avg_real),
    .out_avg_imag      (out_avg_imag),
    .out_avg_time      (out_avg_time),
    .out_avg_interval  (out_avg_interval),
    .out_rows_in_group (out_rows_in_group),
    .out_last          (out_last)
  );

endmodule

/* hdl/wvga_checker.sv */
// port-level checks of the averager, bound to the top level
`include "weighted_visibility_group_average_macros.svh"

module wvga_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_avg_real,
  input logic [15:0] out_rows_in_group
);

  // no new transaction is taken while a group is being emitted
  `WVGA_ASSERT_NOW(a_emit_blocks_input, out_valid, in_stall, "input taken during emission")

  // an emitted group always holds at least one row
  `WVGA_ASSERT_NOW(a_rows_nonzero, out_valid, out_rows_in_group != 16'd0, "empty group emitted")

  // a stalled result stays valid and its real average holds
  `WVGA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_avg_real),
                   "stalled result changed")

  // reset leaves no result pending
  `WVGA_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid, "result valid after reset")

endmodule

bind weighted_visibility_group_average wvga_checker u_wvga_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_avg_real      (out_avg_real),
  .out_rows_in_group (out_rows_in_group)
);

/* dv/tb_top.sv */
// self-checking testbench of the weighted visibility group averager
`timescale 1ns / 1ps

class vis_average_board;
  // predicted state
  bit [2:0] npol_reg;
  bit [6:0] nchan_reg;
  longint real_acc[64];
  longint imag_acc[64];
  bit [47:0] wsum[4];
  bit [55:0] tsum;
  bit [31:0] isum;
  bit [15:0] rows;
  int unsigned pos_q;
  bit [47:0] key_q;
  bit open_q;
  bit [190:0] pending[$];
  int errors;

  function new();
    npol_reg = 4; nchan_reg = 16; open_q = 0; errors = 0;
    clear();
  endfunction

  function void clear();
    for (int i = 0; i < 64; i++) begin
      real_acc[i] = 0; imag_acc[i] = 0;
    end
    for (int i = 0; i < 4; i++) wsum[i] = 0;
    tsum = 0; isum = 0; rows = 0; pos_q = 0;
  endfunction

  function int unsigned pols();
    if (npol_reg == 0) return 1;
    if (npol_reg > 4) return 4;
    return npol_reg;
  endfunction

  function int unsigned elems();
    int unsigned c, n;
    c = (nchan_reg == 0) ? 1 : nchan_reg;
    n = c * pols();
    return (n > 64) ? 64 : n;
  endfunction

  function bit [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function bit [31:0] quot(longint num, bit [47:0] den);
    bit [63:0] mag, q;
    if (den == 0) return sat32(num);
    mag = (num < 0) ? -num : num;
    q = mag / den;
    if (num < 0) return (q >= 64'h80000000) ? 32'h80000000 : 32'(-q);
    return (q > 64'h7fffffff) ? 32'h7fffffff : q[31:0];
  endfunction

  function longint sadd(longint a, longint b);
    longint s;
    s = a + b;
    if (a >= 0 && b >= 0 && s < 0) return 64'h7fffffffffffffff;
    if (a < 0 && b < 0 && s >= 0) return 64'h8000000000000000;
    return s;
  endfunction

  function void emit_group();
    int unsigned n, np;
    bit [63:0] at, ai;
    bit [190:0] exp_item;
    n = elems(); np = pols(); at = 0; ai = 0;
    if (rows != 0) begin
      at = tsum / rows; ai = isum / rows;
      if (at > 64'hffffffffff) at = 64'hffffffffff;
      if (ai > 64'hffff) ai = 64'hffff;
    end
    for (int unsigned i = 0; i < n; i++) begin
      exp_item = {key_q, 6'(i), quot(real_acc[i], wsum[i % np]),
                  quot(imag_acc[i], wsum[i % np]), at[39:0], ai[15:0],
                  rows, 1'(i + 1 == n)};
      pending.insert(pending.size(), exp_item);
    end
    clear();
  endfunction

  function void set_reg(bit idx, bit [6:0] v);
    if (idx == 0) npol_reg = v[2:0]; else nchan_reg = v;
  endfunction

  function void note_input(bit fn, bit [47:0] key, bit [31:0] re, bit [31:0] im,
                           bit flg, bit [15:0] w, bit [15:0] iv, bit [39:0] t);
    int unsigned n, np, p;
    longint wi;
    bit [56:0] ts;
    bit [32:0] is;
    bit [48:0] ws;
    if (fn) begin
      if (open_q) begin
        emit_group(); open_q = 0;
      end
      return;
    end
    if (open_q && key != key_q) emit_group();
    if (!open_q) clear();
    open_q = 1; key_q = key;
    n = elems(); np = pols(); p = pos_q;
    if (p >= n) p = 0;
    wi = longint'(w) * longint'(iv);
    if (p == 0) begin
      ts = tsum + t; tsum = ts[56] ? '1 : ts[55:0];
      is = isum + iv; isum = is[32] ? '1 : is[31:0];
      if (rows != 16'hffff) rows++;
    end
    if (p < np) begin
      ws = wsum[p] + wi[47:0]; wsum[p] = ws[48] ? '1 : ws[47:0];
    end
    if (!flg) begin
      real_acc[p] = sadd(real_acc[p], longint'(signed'(re)) * wi);
      imag_acc[p] = sadd(imag_acc[p], longint'(signed'(im)) * wi);
    end
    p++;
    pos_q = (p >= n) ? 0 : p;
  endfunction

  function void check_result(bit [190:0] got);
    bit [190:0] exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $realtime, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (exp_r !== got) begin
      $display("%0t: mismatch expected %h actual %h", $realtime, exp_r, got);
      $display("  key %h/%h idx %0d/%0d re %h/%h im %h/%h", exp_r[190:143],
               got[190:143], exp_r[142:137], got[142:137], exp_r[136:105],
               got[136:105], exp_r[104:73], got[104:73]);
      $display("  time %h/%h intv %h/%h rows %h/%h last %b/%b", exp_r[72:33],
               got[72:33], exp_r[32:17], got[32:17], exp_r[16:1], got[16:1],
               exp_r[0], got[0]);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import wvga_pkg::*;

  logic clk, rst_n;
  logic cfg_we, cfg_index;
  logic [6:0] cfg_wdata;
  logic in_valid, in_stall, in_func, in_flagged;
  logic [47:0] in_group_key;
  logic signed [31:0] in_sample_real, in_sample_imag;
  logic [15:0] in_pol_weight, in_row_interval;
  logic [39:0] in_row_time;
  logic out_valid, out_stall, out_last;
  logic [47:0] out_key;
  logic [5:0] out_elem_index;
  logic signed [31:0] out_avg_real, out_avg_imag;
  logic [39:0] out_avg_time;
  logic [15:0] out_avg_interval, out_rows_in_group;

  vis_average_board board;
  longint cycles;
  bit calm;
  logic [47:0] row_key;
  logic [15:0] row_w[4];
  logic [15:0] row_iv;
  logic [39:0] row_t;

  weighted_visibility_group_average u_dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog: ends the run as NOT OK if the bench hangs
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 20000000) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      board.note_input(in_func, in_group_key, in_sample_real, in_sample_imag,
                       in_flagged, in_pol_weight, in_row_interval, in_row_time);
    if (rst_n && out_valid && !out_stall)
      board.check_result({out_key, out_elem_index, out_avg_real, out_avg_imag,
                          out_avg_time, out_avg_interval, out_rows_in_group,
                          out_last});
  end

  // receiver stall pattern
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 37);
    end
  end

  // holds valid and data through the accepting edge; in_valid is left high for the caller to drop
  task automatic send(bit fn, bit [47:0] key, bit [31:0] re, bit [31:0] im,
                      bit flg, bit [15:0] w, bit [15:0] iv, bit [39:0] t);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_func <= fn; in_group_key <= key;
    in_sample_real <= re; in_sample_imag <= im; in_flagged <= flg;
    in_pol_weight <= w; in_row_interval <= iv; in_row_time <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // registers change only once the block is idle
  task automatic write_reg(bit idx, bit [6:0] v);
    in_valid <= 0;
    while (in_stall) @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    board.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  function automatic bit [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($urandom_range(2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  // one full row of the current shape with random content
  task automatic send_row(bit [47:0] key, int unsigned n, int unsigned np);
    row_iv = $urandom_range(3) == 0 ? 16'hffff : 16'($urandom);
    row_t = 40'({$urandom, $urandom});
    for (int i = 0; i < 4; i++)
      row_w[i] = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
    for (int unsigned p = 0; p < n; p++)
      send(0, key, rand_sample(), rand_sample(), $urandom_range(4) == 0,
           row_w[p % np], row_iv, row_t);
  endtask

  initial begin
    int unsigned np, nc, n;
    board = new();
    calm = 0;
    rst_n = 0; cfg_we = 0; cfg_index = CFG_NUM_POL; cfg_wdata = 0;
    in_valid = 0; in_func = 0; in_group_key = 0; in_sample_real = 0;
    in_sample_imag = 0; in_flagged = 0; in_pol_weight = 0;
    in_row_interval = 0; in_row_time = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: flush with nothing open, then extremes at small shape
    send(1, 48'h0, 0, 0, 0, 0, 0, 0);
    write_reg(CFG_NUM_POL, 7'd2);
    write_reg(CFG_CHAN_COUNT, 7'd2);
    send(0, 48'hffffffffffff, 32'h7fffffff, 32'h80000000, 0, 16'hffff,
         16'hffff, 40'hffffffffff);
    send(0, 48'hffffffffffff, 32'h80000000, 32'h7fffffff, 0, 16'h0, 16'hffff,
         40'hffffffffff);
    send(0, 48'hffffffffffff, 32'h1, 32'hffffffff, 1, 16'h0, 16'h0, 40'h0);
    // key change mid-row
    send(0, 48'h0, 32'h00010000, 32'h0, 0, 16'h0100, 16'd10, 40'd5);
    send(0, 48'h1, 32'h00020000, 32'h0, 0, 16'h0100, 16'd10, 40'd5);
    send(1, 48'h1, 0, 0, 0, 0, 0, 0);
    send(1, 48'h1, 0, 0, 0, 0, 0, 0);
    drain();
    // out-of-range registers: pol 0 and 7, chan 0, capped at 64 elements
    write_reg(CFG_NUM_POL, 7'd0);
    write_reg(CFG_CHAN_COUNT, 7'd0);
    send(0, 48'h5, 32'h00030000, 32'h0, 0, 16'h0200, 16'd3, 40'd7);
    send(0, 48'h5, 32'h00030000, 32'h0, 0, 16'h0200, 16'd3, 40'd9);
    write_reg(CFG_NUM_POL, 7'd7);
    write_reg(CFG_CHAN_COUNT, 7'd127);
    send(0, 48'h5, 32'hffff0000, 32'h12345678, 0, 16'h0100, 16'd1, 40'd1);
    send(1, 48'h5, 0, 0, 0, 0, 0, 0);
    drain();

    // random: well-formed rows across shapes, with some noise
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 3);
      np = (ph == 0) ? 1 : (ph == 1) ? 4 : $urandom_range(1, 4);
      nc = (ph == 1) ? 1 : (ph == 5) ? 64 : $urandom_range(1, 4);
      write_reg(CFG_NUM_POL, 7'(np));
      write_reg(CFG_CHAN_COUNT, 7'(nc));
      n = (np * nc > 64) ? 64 : np * nc;
      row_key = 48'({$urandom, $urandom});
      for (int r = 0; r < ((ph == 5) ? 2 : 8); r++) begin
        if ($urandom_range(2) == 0) row_key = 48'({$urandom, $urandom});
        if ($urandom_range(9) == 0)
          send(0, 48'({$urandom, $urandom}), $urandom, $urandom, 1'($urandom),
               16'($urandom), 16'($urandom), 40'({$urandom, $urandom}));
        else if ($urandom_range(9) == 0)
          send(1, row_key, $urandom, $urandom, 0, 0, 0, 0);
        else send_row(row_key, n, np);
      end
      send(1, row_key, 0, 0, 0, 0, 0, 0);
      drain();
    end

    if (board.errors == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end
endmodule
